@@ rtl/core/y86c_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86c_pkg
// shared codes for the y86-64 sequential core
// ----------------------------------------------------------------------------
package y86c_pkg;
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_STEP = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] ST_AOK = 2'd0;
   localparam logic [1:0] ST_HLT = 2'd1;
   localparam logic [1:0] ST_ADR = 2'd2;
   localparam logic [1:0] ST_INS = 2'd3;

   localparam logic [3:0] IC_HALT   = 4'h0;
   localparam logic [3:0] IC_NOP    = 4'h1;
   localparam logic [3:0] IC_CMOV   = 4'h2;
   localparam logic [3:0] IC_IRMOV  = 4'h3;
   localparam logic [3:0] IC_RMMOV  = 4'h4;
   localparam logic [3:0] IC_MRMOV  = 4'h5;
   localparam logic [3:0] IC_OP     = 4'h6;
   localparam logic [3:0] IC_JXX    = 4'h7;
   localparam logic [3:0] IC_CALL   = 4'h8;
   localparam logic [3:0] IC_RET    = 4'h9;
   localparam logic [3:0] IC_PUSH   = 4'hA;
   localparam logic [3:0] IC_POP    = 4'hB;

   localparam logic [3:0] RSP_INDEX = 4'd4;

   localparam logic [1:0] ALU_ADD = 2'd0;
   localparam logic [1:0] ALU_SUB = 2'd1;
   localparam logic [1:0] ALU_AND = 2'd2;
   localparam logic [1:0] ALU_XOR = 2'd3;

   typedef struct packed {
      logic zf;
      logic sf;
      logic of_;
   } flags_type;

   function automatic logic cond_holds(input logic [3:0] fn, input flags_type f);
      logic r;
      begin
         unique case (fn)
            4'd0:    r = 1'b1;
            4'd1:    r = (f.sf ^ f.of_) | f.zf;
            4'd2:    r = f.sf ^ f.of_;
            4'd3:    r = f.zf;
            4'd4:    r = ~f.zf;
            4'd5:    r = ~(f.sf ^ f.of_);
            default: r = ~(f.sf ^ f.of_) & ~f.zf;
         endcase
         return r;
      end
   endfunction
endpackage

@@ rtl/core/y86c_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86c_alu
// shared 64-bit add / subtract / logic unit with flag generation
// ----------------------------------------------------------------------------
module y86c_alu (
   input  logic [1:0]           op,
   input  logic [63:0]          a,
   input  logic [63:0]          b,
   output logic [63:0]          res,
   output y86c_pkg::flags_type  flags
);
   logic as, bs, es;
   always_comb begin
      unique case (op)
         y86c_pkg::ALU_ADD: res = b + a;
         y86c_pkg::ALU_SUB: res = b - a;
         y86c_pkg::ALU_AND: res = b & a;
         default:           res = b ^ a;
      endcase
   end
   assign as = a[63];
   assign bs = b[63];
   assign es = res[63];
   assign flags.zf  = (res == 64'd0);
   assign flags.sf  = es;
   assign flags.of_ = (op == y86c_pkg::ALU_ADD) ? ((as == bs) && (es != as)) :
                      (op == y86c_pkg::ALU_SUB) ? ((as != bs) && (es != bs)) : 1'b0;
endmodule

@@ rtl/core/y86_64_sequential_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_64_sequential_core
// y86-64 sequential core: byte memory, 16 registers, one action per request
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; one result comes
// back on the rsp_ ports with done high for exactly one cycle and cannot be
// stalled. a step walks the byte-wide memory one byte at a time; every
// fetched byte is addressed first and then taken from the registered read
// port. a data store writes one byte per cycle and a data load reads its
// eight bytes in turn, least significant first, with a shared alu used for
// address and result math. mrmovq is the longest step, with ten fetch bytes
// plus an eight-byte load. after reset a clearing pass writes zero to every
// memory byte and register while busy stays high.
module y86_64_sequential_core #(
   parameter int MEM_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [12:0] req_load_address,
   input  logic [7:0]  req_load_byte,
   input  logic [3:0]  req_reg_select,
   output logic        done,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_prog_counter,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_overflow_flag,
   output logic signed [63:0] rsp_reg_value,
   output logic [63:0] rsp_fault_info
);
   localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

   // sequencer codes
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FOP   = 4'd2;  // read opcode byte
   localparam logic [3:0] S_FREG  = 4'd3;  // read register byte
   localparam logic [3:0] S_FC    = 4'd4;  // read constant bytes
   localparam logic [3:0] S_DEC   = 4'd5;  // check ifun, read registers
   localparam logic [3:0] S_EXE   = 4'd6;  // alu
   localparam logic [3:0] S_MEM   = 4'd7;  // data bytes
   localparam logic [3:0] S_WB    = 4'd8;
   localparam logic [3:0] S_RD    = 4'd9;  // popq second register write
   localparam logic [3:0] S_RESP  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;

   logic [7:0]  mem [MEM_BYTES];
   logic [63:0] rf  [16];

   logic [63:0] pc_ff, pc_in;
   y86c_pkg::flags_type cc_ff, cc_in;
   logic [1:0]  stat_ff, stat_in;
   logic [63:0] fault_ff, fault_in;

   logic [1:0]  act_ff, act_in;
   logic [3:0]  sel_ff, sel_in;
   logic [7:0]  op_ff, op_in;
   logic [3:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [63:0] valc_ff, valc_in, vala_ff, vala_in, valb_ff, valb_in;
   logic [63:0] vale_ff, vale_in, valm_ff, valm_in, valp_ff, valp_in;
   logic [63:0] wdata_ff, wdata_in;
   logic        cnd_ff, cnd_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] addr_ff, addr_in;   // byte address being requested
   logic        rdpend_ff, rdpend_in;
   logic [63:0] rv_ff, rv_in;

   // memory port
   logic          mwe;
   logic [AW-1:0] mwa, mra;
   logic [7:0]    mwd, mrd_ff;

   // register file write port
   logic        rwe;
   logic [3:0]  rwa;
   logic [63:0] rwd;

   // alu
   logic [1:0]  alu_op;
   logic [63:0] alu_a, alu_b, alu_res;
   y86c_pkg::flags_type alu_fl;

   y86c_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res), .flags(alu_fl));

   logic [3:0] ic, fn;
   assign ic = op_ff[7:4];
   assign fn = op_ff[3:0];

   function automatic logic byte_ok(input logic [63:0] a);
      return a < 64'(MEM_BYTES);
   endfunction
   function automatic logic quad_ok(input logic [63:0] a);
      return (MEM_BYTES >= 8) && (a <= 64'(MEM_BYTES) - 64'd8);
   endfunction

   always_ff @(posedge clock) begin
      if (mwe) mem[mwa] <= mwd;
      mrd_ff <= mem[mra];
      if (rwe) rf[rwa] <= rwd;
   end

   logic is_store;
   logic [63:0] maddr;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      pc_in = pc_ff; cc_in = cc_ff; stat_in = stat_ff; fault_in = fault_ff;
      act_in = act_ff; sel_in = sel_ff; op_in = op_ff; ra_in = ra_ff; rb_in = rb_ff;
      valc_in = valc_ff; vala_in = vala_ff; valb_in = valb_ff; vale_in = vale_ff;
      valm_in = valm_ff; valp_in = valp_ff; wdata_in = wdata_ff; cnd_in = cnd_ff;
      cnt_in = cnt_ff; addr_in = addr_ff; rdpend_in = 1'b0; rv_in = rv_ff;
      mwe = 1'b0; mwa = '0; mwd = 8'd0; mra = addr_ff[AW-1:0];
      rwe = 1'b0; rwa = '0; rwd = 64'd0;
      alu_op = y86c_pkg::ALU_ADD; alu_a = 64'd0; alu_b = 64'd0;
      is_store = (ic == y86c_pkg::IC_RMMOV) || (ic == y86c_pkg::IC_CALL) ||
                 (ic == y86c_pkg::IC_PUSH);
      maddr = ((ic == y86c_pkg::IC_RET) || (ic == y86c_pkg::IC_POP)) ? vala_ff : vale_ff;
      unique case (state_ff)
         S_CLEAR: begin
            // zero every byte after reset, registers while the clear count is below sixteen
            mwe = 1'b1; mwa = clr_ff[AW-1:0];
            if (clr_ff < (AW+1)'(16)) begin
               rwe = 1'b1; rwa = clr_ff[3:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEM_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               act_in = req_action; sel_in = req_reg_select; rv_in = 64'd0;
               if (req_action == y86c_pkg::ACT_LOAD) begin
                  if (64'(req_load_address) < 64'(MEM_BYTES)) begin
                     mwe = 1'b1; mwa = AW'(req_load_address); mwd = req_load_byte;
                  end
                  state_in = S_RESP;
               end else if (req_action == y86c_pkg::ACT_STEP && stat_ff == y86c_pkg::ST_AOK)
               begin
                  if (!byte_ok(pc_ff)) begin
                     stat_in = y86c_pkg::ST_ADR; fault_in = pc_ff; state_in = S_RESP;
                  end else begin
                     addr_in = pc_ff; state_in = S_FOP; rdpend_in = 1'b1;
                  end
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_FOP: begin
            if (!rdpend_ff) begin
               op_in = mrd_ff;
               valc_in = 64'd0; ra_in = 4'd0; rb_in = 4'd0; cnt_in = 4'd0;
               if (mrd_ff[7:4] > y86c_pkg::IC_POP) begin
                  stat_in = y86c_pkg::ST_INS; fault_in = {56'd0, mrd_ff};
                  state_in = S_RESP;
               end else if (mrd_ff[7:4] == y86c_pkg::IC_HALT ||
                            mrd_ff[7:4] == y86c_pkg::IC_NOP ||
                            mrd_ff[7:4] == y86c_pkg::IC_RET) begin
                  valp_in = pc_ff + 64'd1; state_in = S_DEC;
               end else if (mrd_ff[7:4] == y86c_pkg::IC_JXX ||
                            mrd_ff[7:4] == y86c_pkg::IC_CALL) begin
                  valp_in = pc_ff + 64'd9;
                  if (!quad_ok(pc_ff + 64'd1)) begin
                     stat_in = y86c_pkg::ST_ADR; fault_in = pc_ff + 64'd1;
                     state_in = S_RESP;
                  end else begin
                     addr_in = pc_ff + 64'd1; rdpend_in = 1'b1; state_in = S_FC;
                  end
               end else begin
                  valp_in = (mrd_ff[7:4] == y86c_pkg::IC_CMOV ||
                             mrd_ff[7:4] == y86c_pkg::IC_OP ||
                             mrd_ff[7:4] == y86c_pkg::IC_PUSH ||
                             mrd_ff[7:4] == y86c_pkg::IC_POP) ?
                            pc_ff + 64'd2 : pc_ff + 64'd10;
                  if (!byte_ok(pc_ff + 64'd1)) begin
                     stat_in = y86c_pkg::ST_ADR; fault_in = pc_ff + 64'd1;
                     state_in = S_RESP;
                  end else begin
                     addr_in = pc_ff + 64'd1; rdpend_in = 1'b1; state_in = S_FREG;
                  end
               end
            end
         end
         S_FREG: begin
            if (!rdpend_ff) begin
               ra_in = mrd_ff[7:4]; rb_in = mrd_ff[3:0];
               if (valp_ff == pc_ff + 64'd2) begin
                  state_in = S_DEC;
               end else if (!quad_ok(pc_ff + 64'd2)) begin
                  stat_in = y86c_pkg::ST_ADR; fault_in = pc_ff + 64'd2;
                  state_in = S_RESP;
               end else begin
                  addr_in = pc_ff + 64'd2; rdpend_in = 1'b1; state_in = S_FC;
               end
            end
         end
         S_FC: begin
            // one constant byte at a time, little-endian: the next read is issued after the last byte is captured
            if (!rdpend_ff) begin
               valc_in = {mrd_ff, valc_ff[63:8]};
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd7) begin
                  state_in = S_DEC;
               end else begin
                  addr_in = addr_ff + 64'd1; rdpend_in = 1'b1;
               end
            end
         end
         S_DEC: begin
            if (((ic == y86c_pkg::IC_CMOV || ic == y86c_pkg::IC_JXX) && fn > 4'd6) ||
                (ic == y86c_pkg::IC_OP && fn > 4'd3)) begin
               stat_in = y86c_pkg::ST_INS; fault_in = {56'd0, op_ff};
               state_in = S_RESP;
            end else begin
               vala_in = rf[ra_ff];
               valb_in = rf[rb_ff];
               if (ic == y86c_pkg::IC_CALL || ic == y86c_pkg::IC_RET ||
                   ic == y86c_pkg::IC_PUSH || ic == y86c_pkg::IC_POP)
                  valb_in = rf[y86c_pkg::RSP_INDEX];
               if (ic == y86c_pkg::IC_RET || ic == y86c_pkg::IC_POP)
                  vala_in = rf[y86c_pkg::RSP_INDEX];
               state_in = S_EXE;
            end
         end
         S_EXE: begin
            alu_b = valb_ff;
            unique case (ic)
               y86c_pkg::IC_CMOV:  begin alu_a = vala_ff; alu_op = y86c_pkg::ALU_XOR;
                                   alu_b = 64'd0; end
               y86c_pkg::IC_IRMOV: begin alu_a = valc_ff; alu_op = y86c_pkg::ALU_XOR;
                                   alu_b = 64'd0; end
               y86c_pkg::IC_RMMOV, y86c_pkg::IC_MRMOV: alu_a = valc_ff;
               y86c_pkg::IC_OP:    begin alu_a = vala_ff; alu_op = fn[1:0]; end
               y86c_pkg::IC_CALL, y86c_pkg::IC_PUSH: begin
                  alu_a = 64'd8; alu_op = y86c_pkg::ALU_SUB; end
               y86c_pkg::IC_RET, y86c_pkg::IC_POP: alu_a = 64'd8;
               default: ;
            endcase
            vale_in = alu_res;
            cnd_in = y86c_pkg::cond_holds(fn, cc_ff);
            if (ic == y86c_pkg::IC_OP) cc_in = alu_fl;
            wdata_in = (ic == y86c_pkg::IC_CALL) ? valp_ff : vala_ff;
            cnt_in = 4'd0;
            if (ic == y86c_pkg::IC_HALT) begin
               stat_in = y86c_pkg::ST_HLT; pc_in = 64'd0; state_in = S_RESP;
            end else state_in = S_MEM;
         end
         S_MEM: begin
            if (!(is_store || ic == y86c_pkg::IC_MRMOV || ic == y86c_pkg::IC_RET ||
                  ic == y86c_pkg::IC_POP)) begin
               state_in = S_WB;
            end else if (cnt_ff == 4'd0 && !quad_ok(maddr)) begin
               // data quad out of range
               stat_in = y86c_pkg::ST_ADR; fault_in = maddr; state_in = S_RESP;
            end else if (is_store) begin
               mwe = 1'b1; mwa = AW'(maddr + 64'(cnt_ff)); mwd = wdata_ff[7:0];
               wdata_in = {8'd0, wdata_ff[63:8]};
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd7) state_in = S_WB;
            end else begin
               // loads: issue address, capture the byte in the next cycle
               mra = AW'(maddr + 64'(cnt_ff[2:0]));
               if (cnt_ff != 4'd0) valm_in = {mrd_ff, valm_ff[63:8]};
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd8) state_in = S_WB;
            end
         end
         S_WB: begin
            unique case (ic)
               y86c_pkg::IC_CMOV: if (cnd_ff) begin
                  rwe = 1'b1; rwa = rb_ff; rwd = vale_ff; end
               y86c_pkg::IC_IRMOV, y86c_pkg::IC_OP: begin
                  rwe = 1'b1; rwa = rb_ff; rwd = vale_ff; end
               y86c_pkg::IC_MRMOV: begin rwe = 1'b1; rwa = ra_ff; rwd = valm_ff; end
               y86c_pkg::IC_CALL, y86c_pkg::IC_RET, y86c_pkg::IC_PUSH: begin
                  rwe = 1'b1; rwa = y86c_pkg::RSP_INDEX; rwd = vale_ff; end
               y86c_pkg::IC_POP: begin
                  rwe = 1'b1; rwa = y86c_pkg::RSP_INDEX; rwd = vale_ff;
                  state_in = S_RD; end
               default: ;
            endcase
            if (ic != y86c_pkg::IC_POP) state_in = S_RESP;
            unique case (ic)
               y86c_pkg::IC_JXX:  pc_in = cnd_ff ? valc_ff : valp_ff;
               y86c_pkg::IC_CALL: pc_in = valc_ff;
               y86c_pkg::IC_RET:  pc_in = valm_ff;
               default:           pc_in = valp_ff;
            endcase
         end
         S_RD: begin
            // popq second write: destination after stack pointer
            rwe = 1'b1; rwa = ra_ff; rwd = valm_ff; state_in = S_RESP;
         end
         S_RESP: begin
            if (act_ff == y86c_pkg::ACT_READ) rv_in = rf[sel_ff];
            state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0;
         pc_ff <= 64'd0; cc_ff <= '0; stat_ff <= y86c_pkg::ST_AOK; fault_ff <= 64'd0;
         rdpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         pc_ff <= pc_in; cc_ff <= cc_in; stat_ff <= stat_in; fault_ff <= fault_in;
         rdpend_ff <= rdpend_in;
      end
      act_ff <= act_in; sel_ff <= sel_in; op_ff <= op_in; ra_ff <= ra_in; rb_ff <= rb_in;
      valc_ff <= valc_in; vala_ff <= vala_in; valb_ff <= valb_in; vale_ff <= vale_in;
      valm_ff <= valm_in; valp_ff <= valp_in; wdata_ff <= wdata_in; cnd_ff <= cnd_in;
      cnt_ff <= cnt_in; addr_ff <= addr_in; rv_ff <= rv_in;
   end

   // register file clear at reset: cleared alongside memory
   // (rf writes during clear pass)
   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_OUT);
   assign rsp_status = stat_ff;
   assign rsp_prog_counter = pc_ff;
   assign rsp_zero_flag = cc_ff.zf;
   assign rsp_sign_flag = cc_ff.sf;
   assign rsp_overflow_flag = cc_ff.of_;
   assign rsp_reg_value = rv_ff;
   assign rsp_fault_info = (stat_ff == y86c_pkg::ST_ADR || stat_ff == y86c_pkg::ST_INS) ?
                           fault_ff : 64'd0;

   // a result strobe only follows a response setup cycle
   a_done_after_resp: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(state_ff) == S_RESP) else $error("done without setup");
   // the strobe comes while the core still holds off new requests
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      done |-> busy) else $error("done while idle");
   // status only leaves running on a step, and a fault status then holds
   a_stat: assert property (@(posedge clock) disable iff (reset)
      (stat_ff != y86c_pkg::ST_AOK) |=> (stat_ff == $past(stat_ff)))
      else $error("status left fault");
endmodule
